/* rtl/frame_region_blitter_core_macros.svh */
// Assertion macros shared by the frame region blitter checker.
// Holds no logic of its own.
`ifndef FRAME_REGION_BLITTER_CORE_MACROS_SVH
`define FRAME_REGION_BLITTER_CORE_MACROS_SVH
`define FRB_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FRB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/frb_pkg.sv */
// Package for the frame region blitter: opcodes, states and sizes.
// Used by the top level of the block; depends on nothing.
package frb_pkg;
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int CFG_W = 9;
    localparam int COORD_W = 16;
    localparam int PIX_W = 24;

    typedef enum logic [2:0] {
        OP_WRITE = 3'd0, OP_READ = 3'd1, OP_REPLACE = 3'd2,
        OP_MIRROR_ROWS = 3'd3, OP_MIRROR_COLS = 3'd4, OP_COPY = 3'd5
    } op_t;

    typedef enum logic [0:0] {
        REG_WIDTH = 1'b0, REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SETUP, ST_RD_A, ST_RD_B, ST_WAIT, ST_WR_A, ST_WR_B,
        ST_STEP, ST_OUT
    } state_t;
endpackage

/* rtl/frame_region_blitter_core.sv */
// Frame region blitter top level: one frame memory and a command sequencer.
// Depends on frb_pkg.
// Each command is taken once the previous result has left. Write and undefined
// opcodes pass from setup straight to the output state; an in-image read adds a
// wait state for the memory data. Region commands walk their pixels through the
// single-port frame memory: replace visits every pixel of the active image, copy
// every pixel of the rectangle and a mirror every swapped pixel pair, each step
// reading in RD_A (and RD_B for a mirror), writing in WR_A (and WR_B for a mirror)
// and advancing in STEP, as reads and writes share the one port.
module frame_region_blitter_core #(
    parameter int MAX_WIDTH  = frb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = frb_pkg::MAX_HEIGHT_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode[2:0], x_start[18:3], y_start[34:19], x_end[50:35], y_end[66:51],
    // x_dest[82:67], y_dest[98:83], color_match[122:99], color_new[146:123], zeros
    input  logic [151:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pixel_out[23:0]
    output logic [23:0]  m_tdata,
    // status[0]
    output logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [8:0]   cfg_data
);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int CW = 18;

    logic [23:0] mem [DEPTH];
    logic [23:0] rd_data;
    logic        mem_we;
    logic [AW-1:0] mem_addr;
    logic [23:0] mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data <= mem[mem_addr];
    end

    logic signed [CW-1:0] width_reg, height_reg;
    logic signed [CW-1:0] cfg_clamp;
    logic signed [CW-1:0] cfg_max;

    assign cfg_ready = 1'b1;
    always_comb begin
        cfg_max = (cfg_index == frb_pkg::REG_WIDTH) ? CW'(MAX_WIDTH) : CW'(MAX_HEIGHT);
        cfg_clamp = {{(CW-9){1'b0}}, cfg_data};
        if (cfg_data == 9'd0) begin
            cfg_clamp = CW'(1);
        end else if (cfg_clamp > cfg_max) begin
            cfg_clamp = cfg_max;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= (MAX_WIDTH < 256) ? CW'(MAX_WIDTH) : CW'(256);
            height_reg <= (MAX_HEIGHT < 256) ? CW'(MAX_HEIGHT) : CW'(256);
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == frb_pkg::REG_WIDTH) begin
                width_reg <= cfg_clamp;
            end else begin
                height_reg <= cfg_clamp;
            end
        end
    end

    frb_pkg::state_t state_reg, state_next;
    logic [2:0]  op_reg, op_next;
    logic signed [CW-1:0] xs_reg, ys_reg, xe_reg, ye_reg, xd_reg, yd_reg;
    logic [23:0] cm_reg, cn_reg;
    logic signed [CW-1:0] l_reg, r_reg, t_reg, b_reg, l_next, r_next, t_next, b_next;
    logic signed [CW-1:0] i_reg, j_reg, i_next, j_next;
    logic        rev_y_reg, rev_x_reg, rev_y_next, rev_x_next;
    logic [23:0] tmp_reg, tmp_next;
    logic [23:0] pix_reg, pix_next;
    logic        stat_reg, stat_next;

    function automatic logic signed [CW-1:0] clampv(logic signed [CW-1:0] v,
                                                    logic signed [CW-1:0] hi);
        if (v < 0) return '0;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [AW-1:0] adr(logic signed [CW-1:0] x,
                                          logic signed [CW-1:0] y);
        return {y[YW-1:0], x[XW-1:0]};
    endfunction

    logic signed [CW-1:0] w_c, h_c, ii, jj, ax, ay, bx, by, dx, dy;
    logic        last_x, last_y, dest_ok;

    always_comb begin
        w_c = r_reg - l_reg + CW'(1);
        h_c = b_reg - t_reg + CW'(1);
        ii = rev_x_reg ? (w_c - CW'(1) - i_reg) : i_reg;
        jj = rev_y_reg ? (h_c - CW'(1) - j_reg) : j_reg;
        ax = '0; ay = '0; bx = '0; by = '0;
        last_x = 1'b0; last_y = 1'b0;
        unique case (op_reg)
            frb_pkg::OP_REPLACE: begin
                ax = i_reg; ay = j_reg;
                last_x = (i_reg == width_reg - CW'(1));
                last_y = (j_reg == height_reg - CW'(1));
            end
            frb_pkg::OP_MIRROR_ROWS: begin
                ax = l_reg + i_reg; ay = t_reg + j_reg;
                bx = ax; by = b_reg - j_reg;
                last_x = (ax == r_reg);
                last_y = (t_reg + j_reg + CW'(1) >= b_reg - j_reg - CW'(1));
            end
            frb_pkg::OP_MIRROR_COLS: begin
                ax = l_reg + i_reg; ay = t_reg + j_reg;
                bx = r_reg - i_reg; by = ay;
                last_x = (ax + CW'(1) >= bx - CW'(1));
                last_y = (ay == b_reg);
            end
            default: begin
                ax = l_reg + ii; ay = t_reg + jj;
                bx = xd_reg + ii; by = yd_reg + jj;
                last_x = (i_reg == w_c - CW'(1));
                last_y = (j_reg == h_c - CW'(1));
            end
        endcase
        dx = bx; dy = by;
        dest_ok = (dx >= 0) && (dx < width_reg) && (dy >= 0) && (dy < height_reg);
    end

    logic signed [CW-1:0] sxs, sys, sxe, sye;
    assign sxs = CW'($signed(s_tdata[18:3]));
    assign sys = CW'($signed(s_tdata[34:19]));
    assign sxe = CW'($signed(s_tdata[50:35]));
    assign sye = CW'($signed(s_tdata[66:51]));

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            xs_reg <= sxs; ys_reg <= sys; xe_reg <= sxe; ye_reg <= sye;
            xd_reg <= CW'($signed(s_tdata[82:67]));
            yd_reg <= CW'($signed(s_tdata[98:83]));
            cm_reg <= s_tdata[122:99];
            cn_reg <= s_tdata[146:123];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= frb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        op_reg <= op_next;
        l_reg <= l_next; r_reg <= r_next; t_reg <= t_next; b_reg <= b_next;
        i_reg <= i_next; j_reg <= j_next;
        rev_x_reg <= rev_x_next; rev_y_reg <= rev_y_next;
        tmp_reg <= tmp_next; pix_reg <= pix_next; stat_reg <= stat_next;
    end

    logic in_img;
    assign in_img = (xs_reg >= 0) && (xs_reg < width_reg) &&
                    (ys_reg >= 0) && (ys_reg < height_reg);

    always_comb begin
        state_next = state_reg;
        op_next = op_reg;
        l_next = l_reg; r_next = r_reg; t_next = t_reg; b_next = b_reg;
        i_next = i_reg; j_next = j_reg;
        rev_x_next = rev_x_reg; rev_y_next = rev_y_reg;
        tmp_next = tmp_reg; pix_next = pix_reg; stat_next = stat_reg;
        s_tready = 1'b0;
        mem_we = 1'b0;
        mem_addr = adr(ax, ay);
        mem_wdata = cn_reg;
        unique case (state_reg)
            frb_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next = s_tdata[2:0];
                    state_next = frb_pkg::ST_SETUP;
                end
            end
            frb_pkg::ST_SETUP: begin
                l_next = clampv((xs_reg < xe_reg) ? xs_reg : xe_reg, width_reg - CW'(1));
                r_next = clampv((xs_reg < xe_reg) ? xe_reg : xs_reg, width_reg - CW'(1));
                t_next = clampv((ys_reg < ye_reg) ? ys_reg : ye_reg, height_reg - CW'(1));
                b_next = clampv((ys_reg < ye_reg) ? ye_reg : ys_reg, height_reg - CW'(1));
                i_next = '0; j_next = '0;
                pix_next = '0; stat_next = 1'b0;
                state_next = frb_pkg::ST_RD_A;
                case (op_reg)
                    frb_pkg::OP_WRITE, frb_pkg::OP_READ: begin
                        mem_addr = adr(xs_reg, ys_reg);
                        if (!in_img) begin
                            stat_next = 1'b1;
                            state_next = frb_pkg::ST_OUT;
                        end else if (op_reg == frb_pkg::OP_WRITE) begin
                            mem_we = 1'b1;
                            state_next = frb_pkg::ST_OUT;
                        end else begin
                            state_next = frb_pkg::ST_WAIT;
                        end
                    end
                    frb_pkg::OP_REPLACE, frb_pkg::OP_COPY: ;
                    frb_pkg::OP_MIRROR_ROWS: begin
                        if (!(t_next < b_next)) state_next = frb_pkg::ST_OUT;
                    end
                    frb_pkg::OP_MIRROR_COLS: begin
                        if (!(l_next < r_next)) state_next = frb_pkg::ST_OUT;
                    end
                    default: begin
                        stat_next = 1'b1;
                        state_next = frb_pkg::ST_OUT;
                    end
                endcase
                rev_y_next = (yd_reg > t_next);
                rev_x_next = (yd_reg == t_next) && (xd_reg > l_next);
            end
            frb_pkg::ST_WAIT: begin
                pix_next = rd_data;
                state_next = frb_pkg::ST_OUT;
            end
            frb_pkg::ST_RD_A: begin
                mem_addr = adr(ax, ay);
                state_next = (op_reg == frb_pkg::OP_MIRROR_ROWS ||
                              op_reg == frb_pkg::OP_MIRROR_COLS) ?
                             frb_pkg::ST_RD_B : frb_pkg::ST_WR_A;
            end
            frb_pkg::ST_RD_B: begin
                mem_addr = adr(bx, by);
                tmp_next = rd_data;
                state_next = frb_pkg::ST_WR_A;
            end
            frb_pkg::ST_WR_A: begin
                case (op_reg)
                    frb_pkg::OP_REPLACE: begin
                        mem_addr = adr(ax, ay);
                        mem_we = (rd_data == cm_reg);
                        mem_wdata = cn_reg;
                        state_next = frb_pkg::ST_STEP;
                    end
                    frb_pkg::OP_COPY: begin
                        mem_addr = adr(dx, dy);
                        mem_we = dest_ok;
                        mem_wdata = rd_data;
                        state_next = frb_pkg::ST_STEP;
                    end
                    default: begin
                        mem_addr = adr(ax, ay);
                        mem_we = 1'b1;
                        mem_wdata = rd_data;
                        state_next = frb_pkg::ST_WR_B;
                    end
                endcase
            end
            frb_pkg::ST_WR_B: begin
                mem_addr = adr(bx, by);
                mem_we = 1'b1;
                mem_wdata = tmp_reg;
                state_next = frb_pkg::ST_STEP;
            end
            frb_pkg::ST_STEP: begin
                state_next = frb_pkg::ST_RD_A;
                if (last_x) begin
                    i_next = '0;
                    j_next = j_reg + CW'(1);
                    if (last_y) state_next = frb_pkg::ST_OUT;
                end else begin
                    i_next = i_reg + CW'(1);
                end
            end
            frb_pkg::ST_OUT: begin
                if (m_tready) state_next = frb_pkg::ST_IDLE;
            end
            default: state_next = frb_pkg::ST_IDLE;
        endcase
    end

    assign m_tvalid = (state_reg == frb_pkg::ST_OUT);
    assign m_tdata = pix_reg;
    assign m_tuser = stat_reg;
endmodule

/* rtl/frb_checker.sv */
// Port-level checker for the frame region blitter, bound to its top level.
// Depends on the assertion macro header.
`include "frame_region_blitter_core_macros.svh"
module frb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser
);
    `FRB_ASSERT_IMPL(a_no_take_while_out, aclk, aresetn, m_tvalid, !s_tready)
    `FRB_ASSERT_NEXT(a_take_no_result, aclk, aresetn, s_tvalid && s_tready, !m_tvalid)
    `FRB_ASSERT_IMPL(a_ignored_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == 24'd0)
    `FRB_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind frame_region_blitter_core frb_checker u_frb_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
